### rtl/rfa_pkg.sv
// Shared types and constants for the rational fraction ALU.
// Request structs, operation codes, datapath widths and output saturation.
// Used by every module in rtl/.
package rfa_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int MAG_W         = 2 * OPERAND_WIDTH;
  localparam int CNT_W         = $clog2(MAG_W + 1);

  localparam int NUMER_W = 32;
  localparam int DENOM_W = 31;
  localparam int WHOLE_W = 32;
  localparam int REM_W   = 30;

  localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;
  localparam logic [63:0]        DEN_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0]        REM_MAX = 64'h0000_0000_3FFF_FFFF;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef struct packed {
    logic signed [OPERAND_WIDTH-1:0] numer_a;
    logic signed [OPERAND_WIDTH-1:0] denom_a;
    logic signed [OPERAND_WIDTH-1:0] numer_b;
    logic signed [OPERAND_WIDTH-1:0] denom_b;
    cmd_t                            command;
  } in_req_t;

  typedef struct packed {
    logic signed [NUMER_W-1:0] result_numer;
    logic        [DENOM_W-1:0] result_denom;
    logic signed [WHOLE_W-1:0] whole_part;
    logic        [REM_W-1:0]   frac_remainder;
    logic                      error;
  } out_req_t;

  function automatic logic signed [NUMER_W-1:0] clamp_s32(input logic signed [63:0] x);
    if (x > SAT_HI) begin
      return 32'sh7FFF_FFFF;
    end else if (x < SAT_LO) begin
      return 32'sh8000_0000;
    end else begin
      return signed'(x[NUMER_W-1:0]);
    end
  endfunction

endpackage

### rtl/rational_fraction_alu.sv
// Top level of the rational fraction ALU: sequencer, operand and result registers.
// Instantiates rfa_mul, rfa_gcd and rfa_div; types from rfa_pkg.
//
//   port group   dir  handshake           payload
//   in_          in   in_valid/in_ready   rfa_pkg::in_req_t  (two fractions, command)
//   out_         out  out_valid/out_ready rfa_pkg::out_req_t (reduced fraction, mixed form)
//
// An item goes from acceptance to out_valid through the multiplier states S_MUL0 to S_MUL3,
// S_FORM to form the fraction, the binary gcd steps, then three divisions (numerator and
// denominator by the gcd, whole part).
// An error result goes from S_IDLE straight to S_DONE, a zero result from S_FORM to S_DONE.
// in_ready is high only while the sequencer is idle; a finished result waits in the output
// register, so the next request is taken while out_ready is low.
// Reset is synchronous, active low, and clears the sequencer and out_valid.
module rational_fraction_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rfa_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rfa_pkg::out_req_t  out_data
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_MUL0 = 11'b000_0000_0010,
    S_MUL1 = 11'b000_0000_0100,
    S_MUL2 = 11'b000_0000_1000,
    S_MUL3 = 11'b000_0001_0000,
    S_FORM = 11'b000_0010_0000,
    S_GCD  = 11'b000_0100_0000,
    S_DIVN = 11'b000_1000_0000,
    S_DIVD = 11'b001_0000_0000,
    S_DIVW = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

  state_t                            state_r;
  rfa_pkg::in_req_t                  req_r;
  logic signed [rfa_pkg::PROD_W-1:0] t0_r;
  logic signed [rfa_pkg::PROD_W-1:0] t1_r;
  logic signed [rfa_pkg::PROD_W-1:0] t2_r;
  logic [rfa_pkg::MAG_W-1:0]         un_r;
  logic [rfa_pkg::MAG_W-1:0]         ud_r;
  logic                              neg_r;
  rfa_pkg::out_req_t                 res_r;
  rfa_pkg::out_req_t                 out_data_r;
  logic                              out_valid_r;

  logic signed [rfa_pkg::OPERAND_WIDTH-1:0] mul_a;
  logic signed [rfa_pkg::OPERAND_WIDTH-1:0] mul_b;
  logic signed [rfa_pkg::PROD_W-1:0]        prod;

  logic signed [rfa_pkg::PROD_W:0]   num_w;
  logic signed [rfa_pkg::PROD_W-1:0] den_w;
  logic signed [rfa_pkg::PROD_W:0]   num_abs;
  logic signed [rfa_pkg::PROD_W-1:0] den_abs;
  logic [rfa_pkg::MAG_W-1:0]         num_mag;
  logic [rfa_pkg::MAG_W-1:0]         den_mag;

  logic                      gcd_start;
  logic                      gcd_done;
  logic [rfa_pkg::MAG_W-1:0] gcd_val;
  logic                      div_start;
  logic                      div_done;
  logic [rfa_pkg::MAG_W-1:0] div_dividend;
  logic [rfa_pkg::MAG_W-1:0] div_divisor;
  logic [rfa_pkg::MAG_W-1:0] div_quot;
  logic [rfa_pkg::MAG_W-1:0] div_rem;

  logic                      in_bad;
  logic signed [63:0]        un_s;
  logic signed [63:0]        wh_s;
  rfa_pkg::out_req_t         fin_res;
  rfa_pkg::out_req_t         err_res;
  rfa_pkg::out_req_t         zero_res;

  rfa_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  rfa_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a_in  (num_mag),
    .b_in  (den_mag),
    .done  (gcd_done),
    .gcd   (gcd_val)
  );

  rfa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .remain   (div_rem)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_bad = (in_data.denom_a == '0) || (in_data.denom_b == '0) ||
                  ((in_data.command == rfa_pkg::CMD_DIV) && (in_data.numer_b == '0));

  always_comb begin
    unique case (state_r)
      S_MUL0: begin
        mul_a = req_r.numer_a;
        mul_b = (req_r.command == rfa_pkg::CMD_MUL) ? req_r.numer_b : req_r.denom_b;
      end
      S_MUL1: begin
        mul_a = req_r.numer_b;
        mul_b = req_r.denom_a;
      end
      default: begin
        mul_a = req_r.denom_a;
        mul_b = req_r.denom_b;
      end
    endcase
  end

  always_comb begin
    unique case (req_r.command)
      rfa_pkg::CMD_ADD: num_w = (rfa_pkg::PROD_W+1)'(t0_r) + (rfa_pkg::PROD_W+1)'(t1_r);
      rfa_pkg::CMD_SUB: num_w = (rfa_pkg::PROD_W+1)'(t0_r) - (rfa_pkg::PROD_W+1)'(t1_r);
      default:          num_w = (rfa_pkg::PROD_W+1)'(t0_r);
    endcase
    den_w   = (req_r.command == rfa_pkg::CMD_DIV) ? t1_r : t2_r;
    num_abs = num_w[rfa_pkg::PROD_W] ? -num_w : num_w;
    den_abs = den_w[rfa_pkg::PROD_W-1] ? -den_w : den_w;
    num_mag = num_abs[rfa_pkg::MAG_W-1:0];
    den_mag = den_abs[rfa_pkg::MAG_W-1:0];
  end

  assign gcd_start = (state_r == S_FORM) && (num_w != '0);

  always_comb begin
    unique case (state_r)
      S_GCD: begin
        div_dividend = un_r;
        div_divisor  = gcd_val;
      end
      S_DIVN: begin
        div_dividend = ud_r;
        div_divisor  = gcd_val;
      end
      default: begin
        div_dividend = un_r;
        div_divisor  = div_quot;
      end
    endcase
  end

  assign div_start = ((state_r == S_GCD) && gcd_done) ||
                     (((state_r == S_DIVN) || (state_r == S_DIVD)) && div_done);

  always_comb begin
    un_s = signed'(64'(un_r));
    wh_s = signed'(64'(div_quot));
    fin_res.result_numer   = rfa_pkg::clamp_s32(neg_r ? -un_s : un_s);
    fin_res.whole_part     = rfa_pkg::clamp_s32(neg_r ? -wh_s : wh_s);
    fin_res.result_denom   = (64'(ud_r) > rfa_pkg::DEN_MAX) ? '1 : rfa_pkg::DENOM_W'(ud_r);
    fin_res.frac_remainder = (64'(div_rem) > rfa_pkg::REM_MAX) ? '1 : rfa_pkg::REM_W'(div_rem);
    fin_res.error          = 1'b0;

    err_res       = '0;
    err_res.error = 1'b1;

    zero_res              = '0;
    zero_res.result_denom = rfa_pkg::DENOM_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= in_bad ? S_DONE : S_MUL0;
          end
        end
        S_MUL0: state_r <= S_MUL1;
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: state_r <= S_MUL3;
        S_MUL3: state_r <= S_FORM;
        S_FORM: state_r <= (num_w == '0) ? S_DONE : S_GCD;
        S_GCD: begin
          if (gcd_done) begin
            state_r <= S_DIVN;
          end
        end
        S_DIVN: begin
          if (div_done) begin
            state_r <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_done) begin
            state_r <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
      res_r <= err_res;
    end
    if (state_r == S_MUL1) begin
      t0_r <= prod;
    end
    if (state_r == S_MUL2) begin
      t1_r <= prod;
    end
    if (state_r == S_MUL3) begin
      t2_r <= prod;
    end
    if (state_r == S_FORM) begin
      un_r  <= num_mag;
      ud_r  <= den_mag;
      neg_r <= num_w[rfa_pkg::PROD_W] ^ den_w[rfa_pkg::PROD_W-1];
      res_r <= zero_res;
    end
    if ((state_r == S_DIVN) && div_done) begin
      un_r <= div_quot;
    end
    if ((state_r == S_DIVD) && div_done) begin
      ud_r <= div_quot;
    end
    if ((state_r == S_DIVW) && div_done) begin
      res_r <= fin_res;
    end
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_data_r <= res_r;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an accepted request");

  a_error_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error) |->
      ((out_data.result_denom == '0) && (out_data.result_numer == '0)))
    else $error("error result carries a nonzero fraction");

  a_denom_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.error) |-> (out_data.result_denom != '0))
    else $error("valid result with zero denominator");

  a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && !out_valid) |=> out_valid)
    else $error("finished request not moved to the output register");

endmodule

### rtl/rfa_mul.sv
// Registered signed multiplier for the rational fraction ALU.
// One operand pair per cycle, product registered in the next cycle.
// Depends on rfa_pkg for widths.
module rfa_mul (
  input  logic                                     clk,
  input  logic signed [rfa_pkg::OPERAND_WIDTH-1:0] op_a,
  input  logic signed [rfa_pkg::OPERAND_WIDTH-1:0] op_b,
  output logic signed [rfa_pkg::PROD_W-1:0]        prod_r
);

  logic signed [rfa_pkg::PROD_W-1:0] a_ext;
  logic signed [rfa_pkg::PROD_W-1:0] b_ext;

  assign a_ext = rfa_pkg::PROD_W'(op_a);
  assign b_ext = rfa_pkg::PROD_W'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= a_ext * b_ext;
  end

endmodule

### rtl/rfa_gcd.sv
// Binary gcd unit for the rational fraction ALU.
// One shift or subtract step per cycle on two nonzero magnitudes.
// Depends on rfa_pkg for widths.
module rfa_gcd (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rfa_pkg::MAG_W-1:0] a_in,
  input  logic [rfa_pkg::MAG_W-1:0] b_in,
  output logic                      done,
  output logic [rfa_pkg::MAG_W-1:0] gcd
);

  logic [rfa_pkg::MAG_W-1:0] a_r;
  logic [rfa_pkg::MAG_W-1:0] b_r;
  logic [rfa_pkg::CNT_W-1:0] k_r;
  logic                      busy_r;
  logic                      done_r;
  logic                      a_gt_b;
  logic [rfa_pkg::MAG_W-1:0] diff;

  assign a_gt_b = a_r > b_r;
  assign diff   = a_gt_b ? (a_r - b_r) : (b_r - a_r);
  assign done   = done_r;
  assign gcd    = a_r << k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && a_r[0] && b_r[0] && (a_r == b_r)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a_in;
      b_r <= b_in;
      k_r <= '0;
    end else if (busy_r) begin
      priority if (!a_r[0] && !b_r[0]) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (a_r == b_r) begin
        a_r <= a_r;
      end else if (a_gt_b) begin
        a_r <= diff >> 1;
      end else begin
        b_r <= diff >> 1;
      end
    end
  end

endmodule

### rtl/rfa_div.sv
// Restoring divider for the rational fraction ALU.
// One quotient bit per cycle; divisor must be nonzero.
// Depends on rfa_pkg for widths.
module rfa_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rfa_pkg::MAG_W-1:0] dividend,
  input  logic [rfa_pkg::MAG_W-1:0] divisor,
  output logic                      done,
  output logic [rfa_pkg::MAG_W-1:0] quot,
  output logic [rfa_pkg::MAG_W-1:0] remain
);

  logic [rfa_pkg::MAG_W-1:0] quo_r;
  logic [rfa_pkg::MAG_W-1:0] rem_r;
  logic [rfa_pkg::MAG_W-1:0] den_r;
  logic [rfa_pkg::CNT_W-1:0] cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [rfa_pkg::MAG_W:0]   shifted;
  logic [rfa_pkg::MAG_W:0]   trial;
  logic                      fits;

  assign shifted = {rem_r, quo_r[rfa_pkg::MAG_W-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign fits    = !trial[rfa_pkg::MAG_W];
  assign done    = done_r;
  assign quot    = quo_r;
  assign remain  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == rfa_pkg::CNT_W'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
      cnt_r <= rfa_pkg::CNT_W'(rfa_pkg::MAG_W);
    end else if (busy_r) begin
      rem_r <= fits ? trial[rfa_pkg::MAG_W-1:0] : shifted[rfa_pkg::MAG_W-1:0];
      quo_r <= {quo_r[rfa_pkg::MAG_W-2:0], fits};
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
